[rtl/flash_page_split_command_planner_unit_defines.svh]
`ifndef FLASH_PAGE_SPLIT_COMMAND_PLANNER_UNIT_DEFINES_SVH
`define FLASH_PAGE_SPLIT_COMMAND_PLANNER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FPSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FPSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fpsp_pkg.sv]
package fpsp_pkg;

  localparam int ADDR_W           = 21;
  localparam int LEN_W            = 15;
  localparam int CHUNK_OUT_W      = 10;
  localparam int MAX_CHUNKS       = 33;
  localparam int CNT_W            = $clog2(MAX_CHUNKS);
  localparam int DEF_PAGE_BYTES   = 512;
  localparam int DEF_MAX_TRANSFER = 16384;

  localparam logic [7:0] OP_PAGE_READ     = 8'hD2;
  localparam logic [7:0] OP_XFER_TO_BUF   = 8'h53;
  localparam logic [7:0] OP_PROG_THRU_BUF = 8'h82;
  localparam logic [7:0] OP_NONE          = 8'h00;
  localparam logic [2:0] READ_DUMMIES     = 3'd4;
  localparam logic [2:0] NO_DUMMIES       = 3'd0;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  transfer_length;
  } req_t;

  typedef struct packed {
    logic [7:0]             first_opcode;
    logic [7:0]             second_opcode;
    logic [4:0]             addr_upper;
    logic [7:0]             addr_middle;
    logic [7:0]             addr_lower;
    logic [2:0]             dummy_count;
    logic [CHUNK_OUT_W-1:0] chunk_bytes;
    logic                   last_chunk;
  } frame_t;

endpackage

[rtl/fpsp_step_unit.sv]
module fpsp_step_unit #(
  parameter int PAGE_BYTES = fpsp_pkg::DEF_PAGE_BYTES,
  localparam int OFF_W = $clog2(PAGE_BYTES)
) (
  input  logic                      write_mode,
  input  logic [fpsp_pkg::ADDR_W-1:0] cursor,
  input  logic [OFF_W-1:0]          offset,
  input  logic [fpsp_pkg::LEN_W-1:0]  bytes_left,
  input  logic [fpsp_pkg::CNT_W-1:0]  count,
  output logic [fpsp_pkg::ADDR_W-1:0] cursor_next,
  output logic [OFF_W-1:0]          offset_next,
  output logic [fpsp_pkg::LEN_W-1:0]  bytes_left_next,
  output fpsp_pkg::frame_t          frame
);
  import fpsp_pkg::*;

  localparam int CHUNK_W = OFF_W + 1;

  logic [CHUNK_W-1:0] room;
  logic [CHUNK_W-1:0] chunk;
  logic [ADDR_W:0]    sum;
  logic               last;

  // two subtracts, three compares and one add per chunk
  always_comb begin
    room            = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(offset);
    chunk           = (bytes_left < LEN_W'(room)) ? CHUNK_W'(bytes_left) : room;
    bytes_left_next = bytes_left - LEN_W'(chunk);
    sum             = {1'b0, cursor} + (ADDR_W + 1)'(chunk);
    cursor_next     = sum[ADDR_W-1:0];
    // past the top of the array the cursor lands inside the first page
    offset_next     = sum[ADDR_W] ? sum[OFF_W-1:0] : '0;
    last            = (bytes_left_next == '0) || (count == CNT_W'(MAX_CHUNKS - 1));

    frame.first_opcode  = write_mode ? OP_XFER_TO_BUF : OP_PAGE_READ;
    frame.second_opcode = write_mode ? OP_PROG_THRU_BUF : OP_NONE;
    frame.addr_upper    = cursor[20:16];
    frame.addr_middle   = cursor[15:8];
    frame.addr_lower    = cursor[7:0];
    frame.dummy_count   = write_mode ? NO_DUMMIES : READ_DUMMIES;
    frame.chunk_bytes   = CHUNK_OUT_W'(chunk);
    frame.last_chunk    = last;
  end

endmodule

[rtl/flash_page_split_command_planner_unit.sv]
// start loads the request and moves to S_RUN, which registers one frame per cycle into result
// a request gives at most 33 frames and a zero-length one none; busy drops as the last frame shows
// the page offset of the start address is a mask for power-of-two page sizes; otherwise a
// reciprocal multiply in states S_DIV and S_REM finds it before a nonempty request reaches S_RUN
// the result strobe cannot be held off; reset leaves the block idle with no strobe
module flash_page_split_command_planner_unit #(
  parameter int PAGE_BYTES   = fpsp_pkg::DEF_PAGE_BYTES,
  parameter int MAX_TRANSFER = fpsp_pkg::DEF_MAX_TRANSFER
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fpsp_pkg::req_t   request,
  output logic             busy,
  output logic             result_valid,
  output fpsp_pkg::frame_t result
);
  import fpsp_pkg::*;

  localparam int  OFF_W     = $clog2(PAGE_BYTES);
  localparam bit  PAGE_POW2 = (PAGE_BYTES == (1 << OFF_W));
  localparam int  SHIFT_W   = ADDR_W + OFF_W;
  localparam int  RECIP_W   = ADDR_W + 2;
  localparam int  MUL_W     = ADDR_W + RECIP_W;
  localparam int  QUOT_W    = ADDR_W + 1 - OFF_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT_W) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_REM, S_RUN} state_t;

  state_t             state;
  logic               write_mode;
  logic [ADDR_W-1:0]  cursor;
  logic [OFF_W-1:0]   offset;
  logic [LEN_W-1:0]   bytes_left;
  logic [CNT_W-1:0]   count;
  logic [QUOT_W-1:0]  quot;

  logic [LEN_W-1:0]   len_clamped;
  logic [QUOT_W-1:0]  quot_next;
  logic [OFF_W-1:0]   rem_offset;

  logic [ADDR_W-1:0]  cursor_next;
  logic [OFF_W-1:0]   offset_next;
  logic [LEN_W-1:0]   bytes_left_next;
  frame_t             frame;

  assign busy = (state != S_IDLE);

  always_comb begin
    len_clamped = (request.transfer_length > LEN_W'(MAX_TRANSFER)) ?
                  LEN_W'(MAX_TRANSFER) : request.transfer_length;
    // page offset by reciprocal multiply, quotient registered in between
    quot_next   = QUOT_W'((MUL_W'(cursor) * MUL_W'(RECIP)) >> SHIFT_W);
    rem_offset  = OFF_W'(cursor) - OFF_W'(quot) * OFF_W'(PAGE_BYTES);
  end

  fpsp_step_unit #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_step (
    .write_mode     (write_mode),
    .cursor         (cursor),
    .offset         (offset),
    .bytes_left     (bytes_left),
    .count          (count),
    .cursor_next    (cursor_next),
    .offset_next    (offset_next),
    .bytes_left_next(bytes_left_next),
    .frame          (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      count        <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            write_mode <= request.command;
            cursor     <= request.start_address;
            bytes_left <= len_clamped;
            count      <= '0;
            if (PAGE_POW2) begin
              offset <= OFF_W'(request.start_address);
            end else begin
              offset <= '0;
            end
            if (len_clamped != '0) begin
              state <= PAGE_POW2 ? S_RUN : S_DIV;
            end
          end
        end
        S_DIV: begin
          quot  <= quot_next;
          state <= S_REM;
        end
        S_REM: begin
          offset <= rem_offset;
          state  <= S_RUN;
        end
        S_RUN: begin
          result       <= frame;
          result_valid <= 1'b1;
          cursor       <= cursor_next;
          offset       <= offset_next;
          bytes_left   <= bytes_left_next;
          count        <= count + 1'b1;
          if (frame.last_chunk) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/fpsp_checker.sv]
`include "flash_page_split_command_planner_unit_defines.svh"

module fpsp_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input fpsp_pkg::req_t   request,
  input logic             busy,
  input logic             result_valid,
  input fpsp_pkg::frame_t result
);
  import fpsp_pkg::*;

  // a nonempty request taken while idle raises busy
  `FPSP_ASSERT_NEXT(a_busy_on_work, start && !busy && request.transfer_length != '0, busy, "nonempty request did not raise busy")

  // frames of one request come back to back
  `FPSP_ASSERT_NEXT(a_frames_contiguous, result_valid && !result.last_chunk, result_valid, "gap between frames of one item")

  // the block frees up exactly as the final frame shows
  `FPSP_ASSERT_NOW(a_idle_on_last, result_valid, result.last_chunk == !busy, "busy disagrees with last frame")

  // read frames carry dummies and no second opcode
  `FPSP_ASSERT_NOW(a_read_frame, result_valid && result.first_opcode == OP_PAGE_READ, result.second_opcode == OP_NONE && result.dummy_count == READ_DUMMIES, "malformed read frame")

endmodule

bind flash_page_split_command_planner_unit fpsp_checker u_fpsp_checker (.*);
